### rtl/core/msm_pkg.sv
// Package: shared constants and types for the multichannel sliding median.
`timescale 1ns / 1ps
package msm_pkg;

	localparam int CHANNELS_DEF    = 6;
	localparam int WINDOW_DEF      = 9;
	localparam int SAMPLE_BITS_DEF = 10;

	typedef struct packed {
		logic clear;
		logic load;
	} sort_ctl_t;

endpackage

### rtl/core/msm_sorter.sv
// Insertion sorter: one sample per load cycle into a sorted register row; gives its middle.
`timescale 1ns / 1ps
module msm_sorter #(
	parameter int WINDOW      = msm_pkg::WINDOW_DEF,
	parameter int SAMPLE_BITS = msm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  msm_pkg::sort_ctl_t     ctl,
	input  logic [SAMPLE_BITS-1:0] value,
	output logic [SAMPLE_BITS-1:0] mid
);
	import msm_pkg::*;

	localparam int MID = WINDOW / 2;

	logic [SAMPLE_BITS-1:0] sorted_q [WINDOW];
	logic [SAMPLE_BITS-1:0] nxt      [WINDOW];
	logic [WINDOW-1:0]      gt;

	// slots start at full scale; a full-scale sample needs no move
	for (genvar k = 0; k < WINDOW; k++) begin : g_slot
		assign gt[k] = sorted_q[k] > value;
		if (k == 0) begin : g_first
			assign nxt[k] = gt[k] ? value : sorted_q[k];
		end else begin : g_rest
			assign nxt[k] = !gt[k] ? sorted_q[k] : (gt[k-1] ? sorted_q[k-1] : value);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sorted_q[k] <= '1;
			end else if (ctl.clear) begin
				sorted_q[k] <= '1;
			end else if (ctl.load) begin
				sorted_q[k] <= nxt[k];
			end
		end
	end

	assign mid = sorted_q[MID];

endmodule

### rtl/core/multichannel_sliding_median.sv
// Top level: per-channel nine-tap running median over a shared sample memory.
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  request  | in_valid, in_ready, channel,     | in
//           | distance                         |
//  result   | out_valid, out_ready,            | out
//           | out_channel, median, median_valid|
//
// A request steps through ST_READ, ST_DRAIN, ST_DONE: the accept writes a nonzero
// sample, then one memory read per window entry feeds the insertion sorter. An
// out-of-range channel skips to ST_DONE. The single memory read port sets the rate.
// Reset clears all entry valid bits, pointers and full flags at once; no clearing pass.
// A stalled result sits in the output register; the next request is still taken.
`timescale 1ns / 1ps
module multichannel_sliding_median #(
	parameter int CHANNELS    = msm_pkg::CHANNELS_DEF,
	parameter int WINDOW      = msm_pkg::WINDOW_DEF,
	parameter int SAMPLE_BITS = msm_pkg::SAMPLE_BITS_DEF,
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [CH_W-1:0]        channel,
	input  logic [SAMPLE_BITS-1:0] distance,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [CH_W-1:0]        out_channel,
	output logic [SAMPLE_BITS-1:0] median,
	output logic                   median_valid
);
	import msm_pkg::*;

	localparam int DEPTH  = CHANNELS * WINDOW;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PTR_W  = $clog2(WINDOW);

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_DRAIN, ST_DONE} state_t;

	state_t                 state_q;
	logic [CH_W-1:0]        ch_q;
	logic                   ch_ok_q;
	logic [ADDR_W-1:0]      base_q;
	logic [PTR_W-1:0]       idx_q;
	logic [PTR_W-1:0]       ptr_q  [CHANNELS];
	logic [CHANNELS-1:0]    full_q;
	logic [DEPTH-1:0]       ent_vld_q;
	logic [SAMPLE_BITS-1:0] mem    [DEPTH];

	logic [SAMPLE_BITS-1:0] rd_data_s1;
	logic                   rd_ok_s1;
	logic                   rd_s1;

	logic                   out_valid_q;
	logic [CH_W-1:0]        out_channel_q;
	logic [SAMPLE_BITS-1:0] median_q;
	logic                   median_valid_q;

	logic                   accept;
	logic                   ch_ok;
	logic                   wr_en;
	logic [ADDR_W-1:0]      base;
	logic [ADDR_W-1:0]      waddr;
	logic [ADDR_W-1:0]      raddr;
	logic [PTR_W-1:0]       wptr;
	logic [PTR_W-1:0]       wptr_nxt;
	logic                   wrap;
	logic                   out_free;
	sort_ctl_t              sctl;
	logic [SAMPLE_BITS-1:0] sval;
	logic [SAMPLE_BITS-1:0] smid;

	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;
	assign ch_ok    = {1'b0, channel} < (CH_W + 1)'(CHANNELS);
	assign wr_en    = accept && ch_ok && (distance != '0);
	assign base     = ADDR_W'(ADDR_W'(channel) * ADDR_W'(WINDOW));
	assign wptr     = ptr_q[channel];
	assign waddr    = base + ADDR_W'(wptr);
	assign wrap     = wptr == PTR_W'(WINDOW - 1);
	assign wptr_nxt = wrap ? '0 : wptr + 1'b1;
	assign raddr    = base_q + ADDR_W'(idx_q);
	assign out_free = !out_valid_q || out_ready;

	assign sctl.clear = accept;
	assign sctl.load  = rd_s1;
	assign sval       = rd_ok_s1 ? rd_data_s1 : '0;

	msm_sorter #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_sorter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sctl),
		.value  (sval),
		.mid    (smid)
	);

	// sample memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= distance;
		end
		rd_data_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			full_q    <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				ptr_q[c] <= '0;
			end
		end else if (wr_en) begin
			ent_vld_q[waddr] <= 1'b1;
			ptr_q[channel]   <= wptr_nxt;
			if (wrap) begin
				full_q[channel] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1    <= 1'b0;
			rd_ok_s1 <= 1'b0;
		end else begin
			rd_s1    <= state_q == ST_READ;
			rd_ok_s1 <= ent_vld_q[raddr];
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ch_q           <= '0;
			ch_ok_q        <= 1'b0;
			base_q         <= '0;
			idx_q          <= '0;
			out_valid_q    <= 1'b0;
			out_channel_q  <= '0;
			median_q       <= '0;
			median_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ch_q    <= channel;
						ch_ok_q <= ch_ok;
						base_q  <= ch_ok ? base : '0;
						idx_q   <= '0;
						state_q <= ch_ok ? ST_READ : ST_DONE;
					end
				end
				ST_READ: begin
					if (idx_q == PTR_W'(WINDOW - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						out_channel_q  <= ch_q;
						median_q       <= ch_ok_q ? smid : '0;
						median_valid_q <= ch_ok_q && full_q[ch_q];
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign out_channel  = out_channel_q;
	assign median       = median_q;
	assign median_valid = median_valid_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("request taken while busy");

	a_valid_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && median_valid |-> {1'b0, out_channel} < (CH_W + 1)'(CHANNELS))
		else $error("valid median on out-of-range channel");

	a_bad_channel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !({1'b0, out_channel} < (CH_W + 1)'(CHANNELS)) |-> median == '0)
		else $error("nonzero median on out-of-range channel");

	a_load_only_reading: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> (state_q == ST_READ || state_q == ST_DRAIN))
		else $error("sorter load outside read sweep");

endmodule
